/* hw/rtl/fsrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsrt_pkg
// Types and constants shared by the split run timer core.
// ----------------------------------------------------------------------------
package fsrt_pkg;

  typedef enum logic [3:0] {
    MODE_TICK       = 4'd0,
    MODE_FREEZE     = 4'd1,
    MODE_FREEZE_RND = 4'd2,
    MODE_STATUS     = 4'd3,
    MODE_STOP       = 4'd4,
    MODE_QUIT       = 4'd5,
    MODE_AREA       = 4'd6,
    MODE_BANK       = 4'd7,
    MODE_ARM        = 4'd8,
    MODE_LOAD       = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    REG_HOLD_FRAMES = 2'd0,
    REG_GATE_MASK   = 2'd1,
    REG_KEEP_SPLITS = 2'd2
  } reg_idx_t;

  localparam int SPLIT_SLOTS = 16;
  localparam int SLOT_W      = 4;
  localparam int STATUS_N    = 9;

  localparam logic [31:0] CAP_TICKS      = 32'd719280;
  localparam logic [31:0] SPLIT_PT_RESET = 32'd4;
  localparam logic [31:0] BASE_RESTART   = 32'hFFFF_FFFC;
  localparam logic [15:0] HOLD_RESET     = 16'd30;
  localparam logic [31:0] MS_MUL         = 32'd1001;
  // ceil(2^33 / 15): (x >> 3) / 15 == x / 120, exact for 29-bit operands
  localparam logic [29:0] RECIP_15       = 30'h2222_2223;

  localparam logic [31:0] STATUS_TABLE [STATUS_N] = '{
    32'h8000_0387, 32'h0000_0882, 32'h0000_0895, 32'h0000_0896, 32'h3800_034B,
    32'h0200_0886, 32'h0000_0884, 32'h0000_0892, 32'h0000_0893
  };

endpackage : fsrt_pkg
`default_nettype wire

/* hw/rtl/frozen_split_run_timer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frozen_split_run_timer_core
// Event driven run timer with hold, latch at cap and split recording.
//
//   channel   dir   handshake          payload
//   s_*       in    tvalid/tready      tuser: mode; tdata: live, status, arm
//   m_*       out   tvalid/tready      tuser: split_valid; tdata: totals, split
//   apb       in    psel/penable       hold_frames, status_gate_mask, keep_splits
//
// One item per cycle sustained while m_tready is not held low; the input register
// loads at accept, then the state update, x1001 multiply and /120 reciprocal
// multiply registers follow before the result is valid.
// Each stage advances when the one after it is empty or moving, so the input
// keeps flowing while a result waits until all four stages hold items.
// rst is synchronous; it restores timer state, config registers and valid flags to their reset values.
// ----------------------------------------------------------------------------
module frozen_split_run_timer_core
  import fsrt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // live_ticks[30:0], status_word[62:31], arm_value[63]
  input  wire logic [3:0]   s_tuser,   // mode[3:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,   // total_ticks[31:0], total_ms[63:32],
                                       // split_ticks[95:64], split_slot[99:96],
                                       // is_stopped[100], zero[103:101]
  output logic [0:0]        m_tuser,   // split_valid[0]
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration
  logic [15:0] hold_frames;
  logic [8:0]  gate_mask;
  logic        keep_splits;
  reg_idx_t    reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_frames <= HOLD_RESET;
      gate_mask   <= '0;
      keep_splits <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_HOLD_FRAMES: hold_frames <= pwdata[15:0];
        REG_GATE_MASK:   gate_mask   <= pwdata[8:0];
        REG_KEEP_SPLITS: keep_splits <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HOLD_FRAMES: prdata = {16'd0, hold_frames};
      REG_GATE_MASK:   prdata = {23'd0, gate_mask};
      REG_KEEP_SPLITS: prdata = {31'd0, keep_splits};
      default:         prdata = '0;
    endcase
  end

  // pipeline flow control
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign s_tready = rdy0;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= s_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // input register
  mode_t       a_mode;
  logic [30:0] a_live;
  logic [31:0] a_status;
  logic        a_arm;

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy0) begin
      a_mode   <= mode_t'(s_tuser);
      a_live   <= s_tdata[30:0];
      a_status <= s_tdata[62:31];
      a_arm    <= s_tdata[63];
    end
  end

  // timer state
  logic [31:0] base_offset, base_offset_next;
  logic [31:0] held_ticks, held_ticks_next;
  logic [31:0] hold_left, hold_left_next;
  logic        stopped_flag, stopped_flag_next;
  logic        restart_armed, restart_armed_next;
  logic [31:0] last_split_point, last_split_point_next;
  logic [15:0] split_count, split_count_next;

  logic [31:0] live32, live_rnd3, live_rnd4;
  logic        st_found, st_en;
  logic [31:0] view_base, view_held, view_hold;
  logic        view_stopped;
  logic [31:0] total_raw, total;
  logic        over;
  logic        sp_valid;
  logic [31:0] sp_len;
  logic [SLOT_W-1:0] slot;
  logic        a_fire;

  assign a_fire    = v0 && rdy1;
  assign live32    = {1'b0, a_live};
  assign live_rnd3 = (live32 + 32'd3) & ~32'd3;
  assign live_rnd4 = (live32 + 32'd4) & ~32'd3;

  always_comb begin
    st_found = 1'b0;
    st_en    = 1'b0;
    for (int i = 0; i < STATUS_N; i++) begin
      if (!st_found && a_status == STATUS_TABLE[i]) begin
        st_found = 1'b1;
        st_en    = gate_mask[i];
      end
    end
  end

  always_comb begin
    base_offset_next      = base_offset;
    held_ticks_next       = held_ticks;
    hold_left_next        = hold_left;
    stopped_flag_next     = stopped_flag;
    restart_armed_next    = restart_armed;
    last_split_point_next = last_split_point;
    split_count_next      = split_count;
    sp_valid              = 1'b0;
    sp_len                = '0;

    unique case (a_mode)
      MODE_TICK: begin
        if (!stopped_flag && hold_left != '0) hold_left_next = hold_left - 32'd1;
      end
      MODE_FREEZE: begin
        held_ticks_next = live32;
        hold_left_next  = {16'd0, hold_frames};
      end
      MODE_FREEZE_RND: begin
        held_ticks_next = live_rnd3;
        hold_left_next  = {16'd0, hold_frames};
      end
      MODE_STATUS: begin
        if (st_en) begin
          held_ticks_next = live32;
          hold_left_next  = {16'd0, hold_frames};
        end
      end
      MODE_STOP: begin
        base_offset_next   = (base_offset + live32 + 32'd4) & ~32'd3;
        stopped_flag_next  = 1'b1;
        restart_armed_next = 1'b1;
      end
      MODE_QUIT: begin
        restart_armed_next = 1'b1;
        held_ticks_next    = live_rnd3;
        hold_left_next     = '1;
      end
      MODE_AREA: begin
        restart_armed_next = 1'b0;
        held_ticks_next    = live_rnd4;
        hold_left_next     = '1;
      end
      MODE_BANK: begin
        if (!stopped_flag && !restart_armed) base_offset_next = base_offset + live32;
      end
      MODE_ARM: begin
        restart_armed_next = a_arm;
      end
      MODE_LOAD: begin
        hold_left_next = '0;
        if (restart_armed) begin
          stopped_flag_next  = 1'b0;
          restart_armed_next = 1'b0;
          base_offset_next   = BASE_RESTART;
        end
        if (!keep_splits) begin
          last_split_point_next = SPLIT_PT_RESET;
          split_count_next      = '0;
        end
      end
      default: ;
    endcase

    // tick reports from the old state, other events from the new one
    if (a_mode == MODE_TICK) begin
      view_base    = base_offset;
      view_held    = held_ticks;
      view_hold    = hold_left;
      view_stopped = stopped_flag;
    end else begin
      view_base    = base_offset_next;
      view_held    = held_ticks_next;
      view_hold    = hold_left_next;
      view_stopped = stopped_flag_next;
    end

    total_raw = view_stopped ? view_base
                             : ((view_hold != '0) ? view_held : live32) + view_base;
    over      = $signed(total_raw) > $signed(CAP_TICKS);
    total     = over ? CAP_TICKS : total_raw;
    slot      = SLOT_W'(split_count_next % 16'(SPLIT_SLOTS));

    if (a_mode == MODE_TICK) begin
      slot = SLOT_W'(split_count % 16'(SPLIT_SLOTS));
      if (over) begin
        base_offset_next  = CAP_TICKS;
        stopped_flag_next = 1'b1;
      end
      if (hold_left_next != '0 && $signed(held_ticks) > $signed(last_split_point)) begin
        sp_valid              = 1'b1;
        sp_len                = held_ticks - last_split_point;
        last_split_point_next = held_ticks;
        split_count_next      = split_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset      <= '0;
      held_ticks       <= '0;
      hold_left        <= '0;
      stopped_flag     <= 1'b0;
      restart_armed    <= 1'b0;
      last_split_point <= SPLIT_PT_RESET;
      split_count      <= '0;
    end else if (a_fire) begin
      base_offset      <= base_offset_next;
      held_ticks       <= held_ticks_next;
      hold_left        <= hold_left_next;
      stopped_flag     <= stopped_flag_next;
      restart_armed    <= restart_armed_next;
      last_split_point <= last_split_point_next;
      split_count      <= split_count_next;
    end
  end

  // result pipeline
  logic [31:0]       s1_total, s2_total, s3_total;
  logic              s1_split, s2_split, s3_split;
  logic [31:0]       s1_len, s2_len, s3_len;
  logic [SLOT_W-1:0] s1_slot, s2_slot, s3_slot;
  logic              s1_stop, s2_stop, s3_stop;
  logic [31:0]       s2_prod;
  logic [25:0]       s3_ms;
  logic [58:0]       recip_full;

  assign recip_full = 59'(s2_prod[31:3]) * 59'(RECIP_15);

  always_ff @(posedge clk) begin
    if (a_fire) begin
      s1_total <= total;
      s1_split <= sp_valid;
      s1_len   <= sp_len;
      s1_slot  <= slot;
      s1_stop  <= stopped_flag_next;
    end
    if (v1 && rdy2) begin
      s2_total <= s1_total;
      s2_prod  <= 32'(s1_total * MS_MUL);
      s2_split <= s1_split;
      s2_len   <= s1_len;
      s2_slot  <= s1_slot;
      s2_stop  <= s1_stop;
    end
    if (v2 && rdy3) begin
      s3_total <= s2_total;
      s3_ms    <= recip_full[58:33];
      s3_split <= s2_split;
      s3_len   <= s2_len;
      s3_slot  <= s2_slot;
      s3_stop  <= s2_stop;
    end
  end

  assign m_tdata = {3'd0, s3_stop, s3_slot, s3_len, {6'd0, s3_ms}, s3_total};
  assign m_tuser = s3_split;

  // checks
  a_total_capped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[31:0]) <= $signed(CAP_TICKS))
    else $error("total above cap");

  a_no_split_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[95:64] == '0)
    else $error("split length without split");

  a_latch: assert property (@(posedge clk) disable iff (rst)
    a_fire && a_mode == MODE_TICK && over |=> stopped_flag && base_offset == CAP_TICKS)
    else $error("cap did not latch");

  a_split_point: assert property (@(posedge clk) disable iff (rst)
    a_fire && sp_valid |=> last_split_point == $past(held_ticks))
    else $error("split point not updated");

endmodule : frozen_split_run_timer_core
`default_nettype wire

/* tb/frozen_split_run_timer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frozen_split_run_timer_core_test
// Self-checking bench for the split run timer core. Timer events are queued
// per configuration phase and fed through the input stream in random bursts.
// The output stream is stalled on a shifting pattern. Every accepted event is
// run through a local model of the timer state, and each output item is
// compared field by field with the oldest predicted readout. Registers are
// written over APB only while the core is drained, and each write is read back.
// ----------------------------------------------------------------------------
module frozen_split_run_timer_core_test;
  import fsrt_pkg::*;

  localparam int          RUN_LIMIT = 500000;
  localparam logic [31:0] RUN_CAP   = 32'd719280;
  localparam logic [31:0] PLAYER_STATES [9] = '{
    32'h8000_0387, 32'h0000_0882, 32'h0000_0895, 32'h0000_0896, 32'h3800_034B,
    32'h0200_0886, 32'h0000_0884, 32'h0000_0892, 32'h0000_0893
  };

  typedef struct packed {
    logic [3:0]  mode;
    logic [30:0] live;
    logic [31:0] status;
    logic        armv;
  } timer_ev_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] ms;
    logic        split_v;
    logic [31:0] split_len;
    logic [3:0]  slot;
    logic        stopped;
  } readout_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // live_ticks[30:0], status_word[62:31], arm_value[63]
  logic [3:0]   s_tuser = '0;   // mode[3:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // total_ticks[31:0], total_ms[63:32], split_ticks[95:64],
                                // split_slot[99:96], is_stopped[100]
  logic [0:0]   m_tuser;        // split_valid[0]
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  frozen_split_run_timer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer model state and register copies
  logic [31:0] base_q, held_q, hold_q, split_pt_q;
  logic        stop_q, armed_q;
  logic [15:0] split_n;
  logic [15:0] cfg_hold;
  logic [8:0]  cfg_mask;
  logic        cfg_keep;

  timer_ev_t event_backlog [$];
  readout_t  due_readouts [$];
  timer_ev_t on_wire = '0;

  int cycles, errors, items_in, results_seen, splits_seen, latched_seen, phases;
  int burst_left, gap_left, stall_left, stall_style;

  function automatic void start_hold(input logic [31:0] value, input logic [31:0] len);
    held_q = value;
    hold_q = len;
  endfunction

  function automatic readout_t advance_timer(input timer_ev_t ev);
    readout_t    r;
    logic [31:0] live32, tot, v;
    int          hit, k;
    r = '0;
    live32 = {1'b0, ev.live};
    hit = -1;
    if (ev.mode == MODE_TICK) begin
      tot = base_q;
      if (!stop_q) begin
        v = live32;
        if (hold_q != 0) begin
          hold_q = hold_q - 32'd1;
          v = held_q;
        end
        tot = v + base_q;
      end
      if ($signed(tot) > $signed(RUN_CAP)) begin
        tot = RUN_CAP;
        base_q = RUN_CAP;
        stop_q = 1'b1;
      end
      r.slot = split_n[3:0];
      if (hold_q != 0 && $signed(held_q) > $signed(split_pt_q)) begin
        r.split_v = 1'b1;
        r.split_len = held_q - split_pt_q;
        split_pt_q = held_q;
        split_n = split_n + 16'd1;
      end
    end else begin
      case (ev.mode)
        MODE_FREEZE: start_hold(live32, {16'd0, cfg_hold});
        MODE_FREEZE_RND: start_hold((live32 + 32'd3) & 32'hFFFF_FFFC, {16'd0, cfg_hold});
        MODE_STATUS: begin
          for (k = 0; k < 9; k++)
            if (hit < 0 && PLAYER_STATES[k] == ev.status) hit = k;
          if (hit >= 0 && cfg_mask[hit]) start_hold(live32, {16'd0, cfg_hold});
        end
        MODE_STOP: begin
          base_q = (base_q + live32 + 32'd4) & 32'hFFFF_FFFC;
          stop_q = 1'b1;
          armed_q = 1'b1;
        end
        MODE_QUIT: begin
          armed_q = 1'b1;
          start_hold((live32 + 32'd3) & 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        end
        MODE_AREA: begin
          armed_q = 1'b0;
          start_hold((live32 + 32'd4) & 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        end
        MODE_BANK: if (!stop_q && !armed_q) base_q = base_q + live32;
        MODE_ARM: armed_q = ev.armv;
        MODE_LOAD: begin
          hold_q = '0;
          if (armed_q) begin
            stop_q = 1'b0;
            armed_q = 1'b0;
            base_q = 32'hFFFF_FFFC;
          end
          if (!cfg_keep) begin
            split_pt_q = 32'd4;
            split_n = '0;
          end
        end
        default: ;
      endcase
      r.slot = split_n[3:0];
      tot = base_q;
      if (!stop_q) tot = ((hold_q != 0) ? held_q : live32) + base_q;
      if ($signed(tot) > $signed(RUN_CAP)) tot = RUN_CAP;
    end
    r.total = tot;
    r.ms = (tot * 32'd1001) / 32'd120;
    r.stopped = stop_q;
    return r;
  endfunction

  task automatic queue_ev(input logic [3:0] m, input logic [30:0] lv,
                          input logic [31:0] st, input logic av);
    timer_ev_t ev;
    ev.mode = m;
    ev.live = lv;
    ev.status = st;
    ev.armv = av;
    event_backlog.push_back(ev);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (event_backlog.size() != 0 || s_tvalid || due_readouts.size() != 0);
  endtask

  // write, then read back over the same select
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] want;
    repeat (6) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_HOLD_FRAMES: cfg_hold = val[15:0];
      REG_GATE_MASK:   cfg_mask = val[8:0];
      default:         cfg_keep = val[0];
    endcase
    want = (idx == REG_HOLD_FRAMES) ? {16'd0, cfg_hold} :
           (idx == REG_GATE_MASK)   ? {23'd0, cfg_mask} : {31'd0, cfg_keep};
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== want) begin
      errors++;
      if (errors <= 10)
        $display("reg %0d readback: expected %h got %h", idx, want, prdata);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_status();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return PLAYER_STATES[$urandom_range(0, 8)];
    if (p < 8) return PLAYER_STATES[$urandom_range(0, 8)] ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // one stage run: optional arm, stage load, then mostly advancing ticks
  task automatic add_run(input int n);
    logic [30:0] lv;
    logic [3:0]  m;
    int          k, p;
    lv = 31'($urandom_range(0, 3000));
    if ($urandom_range(0, 1)) queue_ev(MODE_ARM, lv, $urandom, 1'b1);
    queue_ev(MODE_LOAD, lv, $urandom, 1'($urandom));
    for (k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < 3) lv = 31'($urandom);
      else if (p < 6) lv = 31'($urandom_range(718000, 719400));
      else if (p < 8) lv = 31'd0;
      else lv = lv + 31'($urandom_range(0, 4));
      p = $urandom_range(0, 99);
      if (p < 55) m = MODE_TICK;
      else if (p < 63) m = MODE_FREEZE;
      else if (p < 68) m = MODE_FREEZE_RND;
      else if (p < 76) m = MODE_STATUS;
      else if (p < 78) m = MODE_STOP;
      else if (p < 80) m = MODE_QUIT;
      else if (p < 82) m = MODE_AREA;
      else if (p < 86) m = MODE_BANK;
      else if (p < 91) m = MODE_ARM;
      else if (p < 94) m = MODE_LOAD;
      else if (p < 97) m = 4'($urandom_range(10, 15));
      else m = 4'($urandom_range(0, 15));
      queue_ev(m, lv, (m == MODE_STATUS) ? pick_status() : $urandom, 1'($urandom));
    end
  endtask

  task automatic add_phase(input int n);
    int added;
    added = 0;
    while (added < n) begin
      add_run($urandom_range(20, 60));
      added = event_backlog.size();
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    logic drive_v;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_readouts.push_back(advance_timer(on_wire));
        items_in++;
      end
      if (!s_tvalid || s_tready) begin
        drive_v = 1'b0;
        if (gap_left > 0) gap_left--;
        else if (event_backlog.size() > 0) begin
          on_wire = event_backlog.pop_front();
          drive_v = 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        s_tvalid <= drive_v;
        s_tdata <= {on_wire.armv, on_wire.status, on_wire.live};
        s_tuser <= on_wire.mode;
      end
    end
  end

  // receiver: picks a new random stall style whenever its countdown runs out
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      case (stall_style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= stall_left[2];
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    readout_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.total = m_tdata[31:0];
      got.ms = m_tdata[63:32];
      got.split_v = m_tuser[0];
      got.split_len = m_tdata[95:64];
      got.slot = m_tdata[99:96];
      got.stopped = m_tdata[100];
      results_seen++;
      if (due_readouts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: total %h", got.total);
      end else begin
        want = due_readouts.pop_front();
        if (want.split_v) splits_seen++;
        if (want.stopped) latched_seen++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"item %0d: expected total %h ms %h split %b/%h slot %0d stop %b,",
                      " got total %h ms %h split %b/%h slot %0d stop %b"},
                     results_seen, want.total, want.ms, want.split_v, want.split_len,
                     want.slot, want.stopped, got.total, got.ms, got.split_v,
                     got.split_len, got.slot, got.stopped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("frozen_split_run_timer_core: mismatch");
      $finish;
    end
  end

  initial begin
    int p;
    base_q = '0;
    held_q = '0;
    hold_q = '0;
    split_pt_q = 32'd4;
    stop_q = 1'b0;
    armed_q = 1'b0;
    split_n = '0;
    cfg_hold = 16'd30;
    cfg_mask = '0;
    cfg_keep = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration
    queue_ev(MODE_TICK, 31'd0, 32'd0, 1'b0);
    queue_ev(MODE_TICK, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // saturate and latch
    queue_ev(MODE_TICK, 31'd5, 32'd0, 1'b0);
    queue_ev(MODE_BANK, 31'd100, 32'd0, 1'b0);
    queue_ev(MODE_ARM, 31'd0, 32'd0, 1'b1);
    queue_ev(MODE_LOAD, 31'd0, 32'd0, 1'b0);                 // restart at -4
    queue_ev(MODE_TICK, 31'd0, 32'd0, 1'b0);                 // negative total
    queue_ev(MODE_FREEZE, 31'd100, 32'd0, 1'b0);
    queue_ev(MODE_TICK, 31'd101, 32'd0, 1'b0);               // first split
    queue_ev(MODE_TICK, 31'd102, 32'd0, 1'b0);
    queue_ev(MODE_STATUS, 31'd150, 32'h8000_0387, 1'b0);     // match, gated off
    queue_ev(4'd15, 31'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    wait_drained();
    phases++;

    reg_write(REG_HOLD_FRAMES, 32'd3);
    reg_write(REG_GATE_MASK, 32'h155);
    reg_write(REG_KEEP_SPLITS, 32'd1);
    queue_ev(MODE_STATUS, 31'd180, 32'h0000_0882, 1'b0);     // disabled entry
    queue_ev(MODE_STATUS, 31'd200, 32'h0000_0895, 1'b0);     // enabled entry
    queue_ev(MODE_TICK, 31'd300, 32'd0, 1'b0);
    queue_ev(MODE_STATUS, 31'd250, 32'h1234_5678, 1'b0);     // no match
    queue_ev(MODE_FREEZE_RND, 31'd401, 32'd0, 1'b0);
    queue_ev(MODE_TICK, 31'd402, 32'd0, 1'b0);
    queue_ev(MODE_STOP, 31'd7, 32'd0, 1'b0);
    queue_ev(MODE_TICK, 31'd500, 32'd0, 1'b0);
    queue_ev(MODE_QUIT, 31'd1001, 32'd0, 1'b0);              // endless hold
    queue_ev(MODE_LOAD, 31'd1100, 32'd0, 1'b0);
    queue_ev(MODE_AREA, 31'd2000, 32'd0, 1'b0);
    queue_ev(MODE_TICK, 31'd2100, 32'd0, 1'b0);
    queue_ev(MODE_BANK, 31'd50, 32'd0, 1'b0);
    queue_ev(MODE_ARM, 31'd0, 32'd0, 1'b0);
    wait_drained();
    phases++;

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          reg_write(REG_HOLD_FRAMES, 32'd0);
          reg_write(REG_GATE_MASK, 32'h1FF);
          reg_write(REG_KEEP_SPLITS, 32'd1);
        end
        1: begin
          reg_write(REG_HOLD_FRAMES, 32'd65535);
          reg_write(REG_GATE_MASK, 32'h000);
          reg_write(REG_KEEP_SPLITS, 32'd0);
        end
        default: begin
          reg_write(REG_HOLD_FRAMES, $urandom_range(1, 40));
          reg_write(REG_GATE_MASK, $urandom_range(0, 511));
          reg_write(REG_KEEP_SPLITS, $urandom_range(0, 1));
        end
      endcase
      add_phase(250);
      wait_drained();
      phases++;
    end

    repeat (20) @(posedge clk);
    $display("run covered %0d events in %0d register settings, %0d results checked",
             items_in, phases, results_seen);
    $display("splits recorded: %0d, results with timer stopped: %0d, failures: %0d",
             splits_seen, latched_seen, errors);
    if (errors == 0 && due_readouts.size() == 0)
      $display("frozen_split_run_timer_core: match");
    else
      $display("frozen_split_run_timer_core: mismatch");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fsrt_pkg.sv
hw/rtl/frozen_split_run_timer_core.sv
tb/frozen_split_run_timer_core_test.sv
